@@ rtl/bffa_pkg.sv @@
package bffa_pkg;

    // map geometry
    localparam int MAP_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W       = $clog2(WORD_COUNT);
    localparam int CAND_W     = WA_W + BIT_W;

    // field widths
    localparam int OP_W     = 3;
    localparam int IDX_W    = 10;
    localparam int STAT_W   = 2;
    localparam int LIMIT_W  = 11;
    localparam int CMP_W    = 17;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [LIMIT_W-1:0] ITEMS_RESET = LIMIT_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_SET   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_NONE_FREE    = 2'd1,
        STAT_ALREADY_FREE = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
    } ctl_cmd_t;

    // lowest clear bit of a map word
    function automatic logic [BIT_W-1:0] find_first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/bitmap_first_fit_allocator.sv @@
// sequence: the exec state loads the result register; a new request is taken only in idle
// with the result register empty or being taken, as each is a read-modify-write of one map
// word in the single-port-write word ram (read at accept, write back next)
// reset: synchronous active low; per-word valid and full flags clear, so the
// whole map reads free at once with no clearing pass; items_in_use resets to 1024
module bitmap_first_fit_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bffa_pkg::S_DATA_W-1:0] s_tdata,   // [9:0] item_index
    input  logic [bffa_pkg::S_USER_W-1:0] s_tuser,   // [2:0] req_type
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bffa_pkg::M_DATA_W-1:0] m_tdata,   // [9:0] granted_index, [11:10] status,
                                                     // [12] bit_value
    // items_in_use register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bffa_pkg::LIMIT_W-1:0]  cfg_data
);
    import bffa_pkg::*;

    ctl_cmd_t cmd;

    // controller: request/result handshake and the two-step sequence
    bffa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    // datapath: word ram, full-word summary, find-first logic, result register
    bffa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

`ifndef SYNTHESIS
    // every accepted request is followed by a valid result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result missing after accepted request");

    // the result register is empty whenever a request is being executed
    a_exec_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !m_tvalid)
        else $error("result overwritten before it was taken");

    // a failed allocate never carries a granted index
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[11:10] == STAT_NONE_FREE)) |-> (m_tdata[9:0] == '0))
        else $error("granted index on failed allocate");
`endif

endmodule

@@ rtl/bffa_ram.sv @@
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bffa_ctrl.sv @@
module bffa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bffa_pkg::ctl_cmd_t cmd
);
    import bffa_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
        cmd.accept   = s_tvalid && s_tready;
        cmd.exec     = (state_reg == S_EXEC);
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

@@ rtl/bffa_dp.sv @@
module bffa_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bffa_pkg::ctl_cmd_t             cmd,
    input  logic [bffa_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [bffa_pkg::S_USER_W-1:0]  s_tuser,
    output logic [bffa_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bffa_pkg::LIMIT_W-1:0]   cfg_data
);
    import bffa_pkg::*;

    op_t                  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [WA_W-1:0]      wa_reg;
    logic                 any_free_reg;
    logic [LIMIT_W-1:0]   items_reg;
    logic [WORD_COUNT-1:0] valid_reg, valid_next;
    logic [WORD_COUNT-1:0] full_reg, full_next;
    logic [IDX_W-1:0]     granted_reg, granted_next;
    status_t              status_reg, status_next;
    logic                 bitval_reg, bitval_next;

    logic [WA_W-1:0]      first_open;
    logic [WA_W-1:0]      rd_addr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wdata;
    logic                 we;
    logic [BIT_W-1:0]     bit_sel;
    logic [BIT_W-1:0]     ffz;
    logic [CAND_W-1:0]    cand;
    logic [CMP_W-1:0]     limit;
    logic                 in_map;
    logic                 cur_bit;

    assign cfg_ready = 1'b1;

    // lowest word that still has a free bit
    always_comb begin
        first_open = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (!full_reg[i]) begin
                first_open = WA_W'(i);
            end
        end
    end

    always_comb begin
        if (op_t'(s_tuser[OP_W-1:0]) == OP_ALLOC) begin
            rd_addr = first_open;
        end else begin
            rd_addr = WA_W'(s_tdata[IDX_W-1:0] >> BIT_W);
        end
    end

    bffa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORD_COUNT)
    ) u_map (
        .aclk (aclk),
        .we   (we),
        .waddr(wa_reg),
        .wdata(wdata),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    always_comb begin
        word    = valid_reg[wa_reg] ? ram_rdata : '0;
        bit_sel = idx_reg[BIT_W-1:0];
        mask    = WORD_BITS'(1) << bit_sel;
        cur_bit = word[bit_sel];
        ffz     = find_first_zero(word);
        cand    = {wa_reg, ffz};
        in_map  = CMP_W'(idx_reg) < CMP_W'(MAP_BITS);
        limit   = (CMP_W'(items_reg) > CMP_W'(MAP_BITS)) ? CMP_W'(MAP_BITS)
                                                         : CMP_W'(items_reg);

        we           = 1'b0;
        wdata        = word;
        granted_next = '0;
        status_next  = STAT_OK;
        bitval_next  = 1'b0;
        case (op_reg)
            OP_ALLOC: begin
                if (any_free_reg && (CMP_W'(cand) < limit)) begin
                    we           = 1'b1;
                    wdata        = word | (WORD_BITS'(1) << ffz);
                    granted_next = IDX_W'(cand);
                end else begin
                    status_next = STAT_NONE_FREE;
                end
            end
            OP_FREE: begin
                if (in_map && cur_bit) begin
                    we    = 1'b1;
                    wdata = word & ~mask;
                end else begin
                    status_next = STAT_ALREADY_FREE;
                end
            end
            OP_SET: begin
                we    = in_map;
                wdata = word | mask;
            end
            OP_CLEAR: begin
                we    = in_map;
                wdata = word & ~mask;
            end
            OP_READ: bitval_next = in_map && cur_bit;
            default: ;
        endcase
        we = we && cmd.exec;

        valid_next = valid_reg;
        full_next  = full_reg;
        if (we) begin
            valid_next[wa_reg] = 1'b1;
            full_next[wa_reg]  = &wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            full_reg  <= '0;
            items_reg <= ITEMS_RESET;
        end else begin
            valid_reg <= valid_next;
            full_reg  <= full_next;
            if (cfg_valid && cfg_ready) begin
                items_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= op_t'(s_tuser[OP_W-1:0]);
            idx_reg      <= s_tdata[IDX_W-1:0];
            wa_reg       <= rd_addr;
            any_free_reg <= ~&full_reg;
        end
        if (cmd.exec) begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            bitval_reg  <= bitval_next;
        end
    end

    assign m_tdata = {{(M_DATA_W - IDX_W - STAT_W - 1){1'b0}},
                      bitval_reg, status_reg, granted_reg};

endmodule

@@ test/bitmap_first_fit_allocator_tb.sv @@
module bitmap_first_fit_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    // request type codes past the last defined one are legal on the bus
    localparam int OP_LAST_CODE = (1 << OP_W) - 1;
    // idle cycles around each config write
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [IDX_W-1:0] granted;
        status_t          status;
        logic             bit_value;
    } req_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // [9:0] item_index
    logic [S_USER_W-1:0]   s_tuser   = '0;   // [2:0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [9:0] granted_index, [11:10] status, [12] bit_value
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LIMIT_W-1:0]    cfg_data  = '0;

    // shadow copy of the allocator state
    logic [MAP_BITS-1:0]   used_map_shadow = '0;
    logic [LIMIT_W-1:0]    search_limit    = ITEMS_RESET;
    req_result_t           pending_results[$];

    // random idling switches for each side
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    int mismatches;
    int results_seen;
    int cfg_writes;
    int grants;
    int full_reports;
    int double_frees;
    int op_counts[OP_LAST_CODE + 1];

    bitmap_first_fit_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("timeout: %0d results still pending", pending_results.size());
        $display("FAILURE");
        $finish;
    end

    // first-fit search and bit updates on the shadow map, one result per request
    function automatic req_result_t predict_outcome(input logic [OP_W-1:0] op,
                                                    input logic [IDX_W-1:0] idx);
        req_result_t r;
        int          span;
        r = '{granted: '0, status: STAT_OK, bit_value: 1'b0};
        case (op)
            OP_ALLOC: begin
                // limits above the map size saturate
                span = (int'(search_limit) > MAP_BITS) ? MAP_BITS : int'(search_limit);
                r.status = STAT_NONE_FREE;
                for (int i = 0; i < span; i++) begin
                    if (!used_map_shadow[i]) begin
                        used_map_shadow[i] = 1'b1;
                        r.granted = IDX_W'(i);
                        r.status  = STAT_OK;
                        break;
                    end
                end
            end
            OP_FREE: begin
                if (!used_map_shadow[idx]) begin
                    r.status = STAT_ALREADY_FREE;
                end else begin
                    used_map_shadow[idx] = 1'b0;
                end
            end
            OP_SET:   used_map_shadow[idx] = 1'b1;
            OP_CLEAR: used_map_shadow[idx] = 1'b0;
            OP_READ:  r.bit_value = used_map_shadow[idx];
            default: begin
                // undefined request types leave the map alone and return zeros
            end
        endcase
        return r;
    endfunction

    // bookkeeping and checking on every clock edge
    always @(posedge aclk) begin : result_check
        req_result_t want;
        req_result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                search_limit = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                want = predict_outcome(s_tuser[OP_W-1:0], s_tdata[IDX_W-1:0]);
                op_counts[s_tuser[OP_W-1:0]]++;
                if (s_tuser[OP_W-1:0] == OP_ALLOC && want.status == STAT_OK) grants++;
                if (want.status == STAT_NONE_FREE) full_reports++;
                if (want.status == STAT_ALREADY_FREE) double_frees++;
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.granted   = m_tdata[IDX_W-1:0];
                got.status    = status_t'(m_tdata[IDX_W+STAT_W-1:IDX_W]);
                got.bit_value = m_tdata[IDX_W+STAT_W];
                results_seen++;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result with nothing pending: ",
                                 "granted %0d status %0d bit %0b",
                                 $realtime, got.granted, got.status, got.bit_value);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.granted !== want.granted || got.status !== want.status
                            || got.bit_value !== want.bit_value) begin
                        if (mismatches < 10) begin
                            $display("%0t: result %0d expected granted %0d status %0d ",
                                     $realtime, results_seen, want.granted, want.status,
                                     "bit %0b, got granted %0d status %0d bit %0b",
                                     want.bit_value, got.granted, got.status,
                                     got.bit_value);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= !rx_idle_on || ($urandom_range(99) >= 35);
    end

    // one request transaction; tvalid stays high so back-to-back items need no gap
    task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        if (tx_idle_on && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= S_USER_W'(op);
        s_tdata  <= S_DATA_W'(idx);
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off new requests until every pending result has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_items_in_use(input logic [LIMIT_W-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // field extremes, every request type, double free and undefined types
    task automatic test_directed_ops();
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '1);          // index is ignored on allocate
        send_req(OP_READ,  10'd0);
        send_req(OP_READ,  10'd1023);
        send_req(OP_FREE,  10'd0);
        send_req(OP_FREE,  10'd0);       // double free
        send_req(OP_ALLOC, 10'h2AA);     // reuses the freed slot
        send_req(OP_SET,   10'd1023);
        send_req(OP_READ,  10'd1023);
        send_req(OP_FREE,  10'd1023);
        send_req(OP_FREE,  10'd1023);    // double free at the top index
        send_req(OP_CLEAR, 10'd1);
        send_req(OP_READ,  10'd1);
        send_req(OP_SET,   10'h2AA);
        send_req(OP_SET,   10'h155);
        send_req(OP_READ,  10'h2AA);
        send_req(OP_READ,  10'h155);
        send_req(OP_CLEAR, 10'h2AA);
        send_req(OP_READ,  10'h2AA);
        for (int c = OP_READ + 1; c <= OP_LAST_CODE; c++) begin
            send_req(OP_W'(c), IDX_W'($urandom_range(0, 1023)));
        end
        send_req(OP_ALLOC, '0);
    endtask

    // zero search window, saturating window, a window of one, one below the map size and the reset value
    task automatic test_search_limit();
        write_items_in_use('0);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        write_items_in_use('1);
        send_req(OP_ALLOC, '0);
        write_items_in_use(LIMIT_W'(1));
        send_req(OP_ALLOC, '0);          // slot 0 already taken
        send_req(OP_FREE,  10'd0);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        write_items_in_use(LIMIT_W'(MAP_BITS - 1));
        send_req(OP_ALLOC, '0);
        write_items_in_use(ITEMS_RESET);
        send_req(OP_ALLOC, '0);
    endtask

    // random mix around the search window, allocate-heavy so the map fills up
    task automatic test_random_phase(input int limit, input int count, input bit idle,
                                     input bit mid_drain);
        int pick;
        int hot_hi;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        write_items_in_use(LIMIT_W'(limit));
        tx_idle_on = idle;
        rx_idle_on = idle;
        hot_hi = (limit + 8 > MAP_BITS - 1) ? MAP_BITS - 1 : ((limit < 16) ? 24 : limit + 8);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)      op = OP_ALLOC;
            else if (pick < 65) op = OP_FREE;
            else if (pick < 75) op = OP_SET;
            else if (pick < 85) op = OP_CLEAR;
            else if (pick < 97) op = OP_READ;
            else                op = OP_W'($urandom_range(OP_READ + 1, OP_LAST_CODE));
            if ($urandom_range(99) < 80) idx = IDX_W'($urandom_range(0, hot_hi));
            else                         idx = IDX_W'($urandom_range(0, MAP_BITS - 1));
            // let the pipeline run dry once in the middle
            if (mid_drain && n == count / 2) wait_for_drain();
            send_req(op, idx);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        int phase_limits[10];
        int waited;
        phase_limits = '{8, 40, 1, 2047, 97, 0, 1024, 64, 513, 1023};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_search_limit();
        foreach (phase_limits[p]) begin
            // the 1024 window runs with no idling on either side
            test_random_phase(phase_limits[p], 110, phase_limits[p] != MAP_BITS, p == 1);
        end

        s_tvalid <= 1'b0;
        waited = 0;
        @(posedge aclk);
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("covered %0d requests (alloc %0d, free %0d, set %0d, clear %0d, ",
                 results_seen, op_counts[OP_ALLOC], op_counts[OP_FREE],
                 op_counts[OP_SET], op_counts[OP_CLEAR],
                 "read %0d) over %0d window settings", op_counts[OP_READ], cfg_writes);
        $display("grants %0d, full reports %0d, double frees %0d, mismatches %0d",
                 grants, full_reports, double_frees, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
